// ----- src/mfvn_pkg.sv -----
// ----------------------------------------------------------------------------
// mfvn_pkg: shared definitions for the multifractal value noise block
// constants, sequencer states, register indexes and the cosine helper
// ----------------------------------------------------------------------------
package mfvn_pkg;

    localparam int MAX_OCTAVES_DEF = 16;
    localparam int COS_DEPTH_DEF   = 256;
    localparam int COORD_FRAC_DEF  = 16;
    localparam int FREQ_FRAC_BITS  = 16;

    // register reset values
    localparam logic [4:0]         OCT_CNT_RST = 5'd4;
    localparam logic [23:0]        FREQ_RST    = 24'd65536;
    localparam logic signed [19:0] AMP_RST     = 20'sd65536;
    localparam logic signed [17:0] RATIO_RST   = 18'sd32768;
    localparam logic signed [19:0] OFFS_RST    = 20'sd65536;

    // hash constants
    localparam logic [15:0] HASH_YMUL = 16'd57;
    localparam logic [31:0] HASH_K1   = 32'd15731;
    localparam logic [31:0] HASH_K2   = 32'd789221;
    localparam logic [31:0] HASH_K3   = 32'd1376312589;

    // q.30 working values, wide enough for the q16.16 range
    typedef logic signed [46:0] t_q;
    localparam t_q Q_ONE  = 47'sh0000_4000_0000;
    localparam t_q SAT_HI = 47'sh1FFF_FFFF_C000;
    localparam t_q SAT_LO = 47'sh6000_0000_0000;
    localparam logic [63:0] SAT_HI_MAG = 64'h0000_1FFF_FFFF_C000;
    localparam logic [63:0] SAT_LO_MAG = 64'h0000_2000_0000_0000;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] ONE_Q30_U = 64'h0000_0000_4000_0000;

    localparam logic [63:0] COS_DEN [9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                             64'd132, 64'd182, 64'd240, 64'd306};

    typedef enum logic [2:0] {
        CFG_OCTAVE_COUNT    = 3'd0,
        CFG_BASE_FREQUENCY  = 3'd1,
        CFG_START_AMPLITUDE = 3'd2,
        CFG_AMPLITUDE_RATIO = 3'd3,
        CFG_OCTAVE_OFFSET   = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULX,
        ST_MULY,
        ST_TAKEY,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_HACC,
        ST_LMUL,
        ST_LTAKE,
        ST_OINIT,
        ST_MPP,
        ST_MFIN,
        ST_OUT
    } t_state;

    // cos of an angle in [0, pi/2], q2.30, taylor series to the x^18 term
    function automatic logic [63:0] cos_q30(input logic [63:0] a);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (a * a) >> 30;
        term = ONE_Q30_U;
        sum  = $signed(ONE_Q30_U);
        for (int k = 0; k < 9; k++) begin
            term = ((term * x2) >> 30) / COS_DEN[k];
            if ((k % 2) == 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q30_U)) begin
            sum = $signed(ONE_Q30_U);
        end
        return $unsigned(sum);
    endfunction

endpackage

// ----- src/multifractal_value_noise.sv -----
// ----------------------------------------------------------------------------
// multifractal_value_noise: cosine-interpolated multifractal value noise
// one q16.16 point in, one saturated q16.16 product out
// ----------------------------------------------------------------------------
// usage
//   a request is taken on a rising edge with start high and busy low; the
//   x and y coordinates are sampled then. busy stays high while the point
//   is worked on. the result shows on o_fractal_value and o_saturated, with
//   o_strobe high for exactly one cycle; nothing can hold it off.
// sequence
//   everything runs through one 32x32 multiplier under a small sequencer:
//   the coordinates are scaled and split, each of the 16 lattice points
//   is hashed, the three blends run, the octave loop is set up, each
//   octave step forms four q.30 products of four partial products each
//   plus a finish, and the result is emitted. with n = min(octave_count,
//   MAX_OCTAVES), a request runs max(n-1, 0) octave steps.
//   a new request can be taken in the cycle the strobe shows.
// reset
//   synchronous, active low: the sequencer goes idle, no strobe, and the
//   configuration registers return to their defaults. configuration is
//   to be written via i_cfg_we/i_cfg_idx/i_cfg_data while idle, not enforced.
// ----------------------------------------------------------------------------
module multifractal_value_noise #(
    parameter int MAX_OCTAVES     = mfvn_pkg::MAX_OCTAVES_DEF,
    parameter int COS_TABLE_DEPTH = mfvn_pkg::COS_DEPTH_DEF,
    parameter int COORD_FRAC_BITS = mfvn_pkg::COORD_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_x_coord,
    input  logic [31:0] i_y_coord,
    output logic        o_strobe,
    output logic [31:0] o_fractal_value,
    output logic        o_saturated,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    // split point of the scaled coordinate and table index width
    localparam int SH = COORD_FRAC_BITS + mfvn_pkg::FREQ_FRAC_BITS;
    localparam int IW = $clog2(COS_TABLE_DEPTH);
    localparam int OW = $clog2(MAX_OCTAVES + 1);

    typedef logic [30:0] t_wtab [COS_TABLE_DEPTH];

    // blend weight table (1 - cos(pi*i/depth))/2, built at elaboration
    function automatic t_wtab build_wtab();
        t_wtab       t;
        logic [63:0] ang;
        logic [63:0] c;
        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            if (2 * i <= COS_TABLE_DEPTH) begin
                ang  = (mfvn_pkg::PI_Q30 * 64'(i)) / COS_TABLE_DEPTH;
                c    = mfvn_pkg::cos_q30(ang);
                t[i] = 31'((mfvn_pkg::ONE_Q30_U - c) >> 1);
            end else begin
                ang  = (mfvn_pkg::PI_Q30 * 64'(COS_TABLE_DEPTH - i)) / COS_TABLE_DEPTH;
                c    = mfvn_pkg::cos_q30(ang);
                t[i] = 31'((mfvn_pkg::ONE_Q30_U + c) >> 1);
            end
        end
        return t;
    endfunction

    localparam t_wtab WTAB = build_wtab();

    // configuration registers
    logic [4:0]         r_oct_cnt;
    logic [23:0]        r_freq;
    logic signed [19:0] r_amp0;
    logic signed [17:0] r_ratio;
    logic signed [19:0] r_offs;

    mfvn_pkg::t_state r_state, n_state;

    // request capture
    logic [31:0] r_xmag, r_ymag;
    logic        r_xneg, r_yneg;

    // shared multiplier output
    logic [63:0] r_prod;
    logic [31:0] mul_a, mul_b;

    // lattice cell and blend weights
    logic [15:0] r_cx, r_cy;
    logic [30:0] r_wx, r_wy;

    // lattice walk and smoothing sums, one per cell corner
    logic [3:0]         r_g;
    logic signed [35:0] r_sacc [4];

    // blends
    logic [1:0]         r_lsel;
    logic signed [31:0] r_i1, r_i2;

    // octave loop
    mfvn_pkg::t_q r_nz, r_t1, r_term, r_ret, r_amp;
    logic [1:0]   r_msel, r_pp;
    logic [63:0]  r_acc;
    logic [OW-1:0] r_oct;
    logic         r_sat;

    // result
    logic        r_strobe;
    logic [31:0] r_out_val;
    logic        r_out_sat;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_cnt <= mfvn_pkg::OCT_CNT_RST;
            r_freq    <= mfvn_pkg::FREQ_RST;
            r_amp0    <= mfvn_pkg::AMP_RST;
            r_ratio   <= mfvn_pkg::RATIO_RST;
            r_offs    <= mfvn_pkg::OFFS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfvn_pkg::CFG_OCTAVE_COUNT:    r_oct_cnt <= i_cfg_data[4:0];
                mfvn_pkg::CFG_BASE_FREQUENCY:  r_freq    <= i_cfg_data;
                mfvn_pkg::CFG_START_AMPLITUDE: r_amp0    <= $signed(i_cfg_data[19:0]);
                mfvn_pkg::CFG_AMPLITUDE_RATIO: r_ratio   <= $signed(i_cfg_data[17:0]);
                mfvn_pkg::CFG_OCTAVE_OFFSET:   r_offs    <= $signed(i_cfg_data[19:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // coordinate split: |p| = |coord| * freq, cell truncated toward zero
    // ------------------------------------------------------------------
    logic              sp_neg;
    logic [15:0]       sp_ipl;
    logic [15:0]       sp_cell;
    logic [SH-1:0]     sp_fr;
    logic [SH+IW-1:0]  sp_frs;
    logic [IW-1:0]     sp_idx;
    logic [30:0]       sp_w;

    always_comb begin
        sp_neg  = (r_state == mfvn_pkg::ST_MULY) ? r_xneg : r_yneg;
        sp_ipl  = r_prod[SH+15:SH];
        sp_cell = sp_neg ? 16'(-sp_ipl) : sp_ipl;
        sp_fr   = r_prod[SH-1:0];
        sp_frs  = (SH+IW)'(sp_fr) * (SH+IW)'(COS_TABLE_DEPTH);
        sp_idx  = sp_frs[SH+IW-1:SH];
        sp_w    = WTAB[sp_idx];
    end

    // ------------------------------------------------------------------
    // lattice hash of grid point r_g (4x4 around the cell)
    // ------------------------------------------------------------------
    logic [1:0]         h_gx, h_gy;
    logic [15:0]        h_xl, h_yl, h_sum, h_mix;
    logic [31:0]        h_n;
    logic [31:0]        h_v;
    logic signed [31:0] h_latt;
    logic signed [35:0] h_contrib [4];

    always_comb begin
        int dx;
        int dy;
        int d;
        h_gx   = r_g[1:0];
        h_gy   = r_g[3:2];
        h_xl   = r_cx + {14'b0, h_gx} - 16'd1;
        h_yl   = r_cy + {14'b0, h_gy} - 16'd1;
        h_sum  = h_xl + 16'(h_yl * mfvn_pkg::HASH_YMUL);
        h_mix  = h_sum ^ {h_sum[2:0], 13'b0};
        h_n    = {{16{h_mix[15]}}, h_mix};
        h_v    = r_prod[31:0] + mfvn_pkg::HASH_K3;
        h_latt = 32'sh4000_0000 - $signed({1'b0, h_v[30:0]});
        // corner k sits at grid (1 + k[0], 1 + k[1]); weight 4, 2 or 1
        for (int k = 0; k < 4; k++) begin
            dx = int'(h_gx) - 1 - (k % 2);
            dy = int'(h_gy) - 1 - (k / 2);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            d = dx + dy;
            if (dx <= 1 && dy <= 1) begin
                h_contrib[k] = 36'(h_latt) <<< (2 - d);
            end else begin
                h_contrib[k] = 36'sd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // blend: a + floor((b - a) * w / 2^30)
    // ------------------------------------------------------------------
    logic signed [31:0] l_a, l_b;
    logic [30:0]        l_w;
    logic signed [32:0] l_diff;
    logic               l_neg;
    logic [31:0]        l_mag;
    logic [63:0]        l_q;
    logic signed [32:0] l_qs;
    logic signed [31:0] l_res;

    always_comb begin
        case (r_lsel)
            2'd0: begin
                l_a = 32'(r_sacc[0] >>> 4);
                l_b = 32'(r_sacc[1] >>> 4);
                l_w = r_wx;
            end
            2'd1: begin
                l_a = 32'(r_sacc[2] >>> 4);
                l_b = 32'(r_sacc[3] >>> 4);
                l_w = r_wx;
            end
            default: begin
                l_a = r_i1;
                l_b = r_i2;
                l_w = r_wy;
            end
        endcase
        l_diff = 33'(l_b) - 33'(l_a);
        l_neg  = l_diff[32];
        l_mag  = l_neg ? 32'(-l_diff) : l_diff[31:0];
        l_q    = l_neg ? ((r_prod + 64'h3FFF_FFFF) >> 30) : (r_prod >> 30);
        l_qs   = l_neg ? -$signed({1'b0, l_q[31:0]}) : $signed({1'b0, l_q[31:0]});
        l_res  = 32'(33'(l_a) + l_qs);
    end

    // ------------------------------------------------------------------
    // q.30 product in four partial products, truncated and clamped
    // ------------------------------------------------------------------
    mfvn_pkg::t_q m_a, m_b, m_offs, m_ratio, m_res, m_amp0;
    logic [45:0]  m_ua, m_ub;
    logic [63:0]  m_mag;
    logic         m_neg, m_clamp;

    always_comb begin
        m_offs  = mfvn_pkg::t_q'(r_offs) <<< 14;
        m_ratio = mfvn_pkg::t_q'(r_ratio) <<< 14;
        m_amp0  = mfvn_pkg::t_q'(r_amp0) <<< 14;
        case (r_msel)
            2'd0: begin
                m_a = m_offs;
                m_b = r_nz;
            end
            2'd1: begin
                m_a = r_t1;
                m_b = r_amp;
            end
            2'd2: begin
                m_a = r_ret;
                m_b = r_term;
            end
            default: begin
                m_a = r_amp;
                m_b = m_ratio;
            end
        endcase
        m_ua  = m_a[46] ? 46'(-m_a) : m_a[45:0];
        m_ub  = m_b[46] ? 46'(-m_b) : m_b[45:0];
        m_neg = m_a[46] ^ m_b[46];
        m_mag = r_acc + (r_prod >> 30);
        if (m_neg) begin
            m_clamp = (m_mag > mfvn_pkg::SAT_LO_MAG);
            m_res   = m_clamp ? mfvn_pkg::SAT_LO : 47'(-$signed({1'b0, m_mag[46:0]}));
        end else begin
            m_clamp = (m_mag > mfvn_pkg::SAT_HI_MAG);
            m_res   = m_clamp ? mfvn_pkg::SAT_HI : $signed(m_mag[46:0]);
        end
    end

    // octave step count, capped
    logic [OW-1:0] oct_iters;
    always_comb begin
        int cnt;
        cnt = (int'(r_oct_cnt) > MAX_OCTAVES) ? MAX_OCTAVES : int'(r_oct_cnt);
        oct_iters = (cnt > 1) ? OW'(cnt - 1) : '0;
    end

    // final truncation toward zero to q16.16
    logic [31:0] ret_q16;
    always_comb begin
        ret_q16 = r_ret[46] ? 32'(-((-r_ret) >>> 14)) : 32'(r_ret >>> 14);
    end

    // ------------------------------------------------------------------
    // shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            mfvn_pkg::ST_MULX: begin
                mul_a = r_xmag;
                mul_b = {8'b0, r_freq};
            end
            mfvn_pkg::ST_MULY: begin
                mul_a = r_ymag;
                mul_b = {8'b0, r_freq};
            end
            mfvn_pkg::ST_H1: begin
                mul_a = h_n;
                mul_b = h_n;
            end
            mfvn_pkg::ST_H2: begin
                mul_a = r_prod[31:0];
                mul_b = mfvn_pkg::HASH_K1;
            end
            mfvn_pkg::ST_H3: begin
                mul_a = h_n;
                mul_b = r_prod[31:0] + mfvn_pkg::HASH_K2;
            end
            mfvn_pkg::ST_LMUL: begin
                mul_a = l_mag;
                mul_b = {1'b0, l_w};
            end
            mfvn_pkg::ST_MPP: begin
                case (r_pp)
                    2'd0: begin
                        mul_a = {16'b0, m_ua[45:30]};
                        mul_b = {16'b0, m_ub[45:30]};
                    end
                    2'd1: begin
                        mul_a = {16'b0, m_ua[45:30]};
                        mul_b = {2'b0, m_ub[29:0]};
                    end
                    2'd2: begin
                        mul_a = {2'b0, m_ua[29:0]};
                        mul_b = {16'b0, m_ub[45:30]};
                    end
                    default: begin
                        mul_a = {2'b0, m_ua[29:0]};
                        mul_b = {2'b0, m_ub[29:0]};
                    end
                endcase
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfvn_pkg::ST_IDLE:  if (start) n_state = mfvn_pkg::ST_MULX;
            mfvn_pkg::ST_MULX:  n_state = mfvn_pkg::ST_MULY;
            mfvn_pkg::ST_MULY:  n_state = mfvn_pkg::ST_TAKEY;
            mfvn_pkg::ST_TAKEY: n_state = mfvn_pkg::ST_H1;
            mfvn_pkg::ST_H1:    n_state = mfvn_pkg::ST_H2;
            mfvn_pkg::ST_H2:    n_state = mfvn_pkg::ST_H3;
            mfvn_pkg::ST_H3:    n_state = mfvn_pkg::ST_HACC;
            mfvn_pkg::ST_HACC: begin
                n_state = (r_g == 4'hF) ? mfvn_pkg::ST_LMUL : mfvn_pkg::ST_H1;
            end
            mfvn_pkg::ST_LMUL:  n_state = mfvn_pkg::ST_LTAKE;
            mfvn_pkg::ST_LTAKE: begin
                n_state = (r_lsel == 2'd2) ? mfvn_pkg::ST_OINIT : mfvn_pkg::ST_LMUL;
            end
            mfvn_pkg::ST_OINIT: begin
                n_state = (oct_iters == '0) ? mfvn_pkg::ST_OUT : mfvn_pkg::ST_MPP;
            end
            mfvn_pkg::ST_MPP: begin
                if (r_pp == 2'd3) n_state = mfvn_pkg::ST_MFIN;
            end
            mfvn_pkg::ST_MFIN: begin
                if (r_msel == 2'd3 && r_oct == OW'(1)) begin
                    n_state = mfvn_pkg::ST_OUT;
                end else begin
                    n_state = mfvn_pkg::ST_MPP;
                end
            end
            mfvn_pkg::ST_OUT:   n_state = mfvn_pkg::ST_IDLE;
            default:            n_state = mfvn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfvn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (r_state)
            mfvn_pkg::ST_IDLE: begin
                r_xneg <= i_x_coord[31];
                r_yneg <= i_y_coord[31];
                r_xmag <= i_x_coord[31] ? -i_x_coord : i_x_coord;
                r_ymag <= i_y_coord[31] ? -i_y_coord : i_y_coord;
                r_sat  <= 1'b0;
            end
            mfvn_pkg::ST_MULY: begin
                r_cx <= sp_cell;
                r_wx <= sp_w;
            end
            mfvn_pkg::ST_TAKEY: begin
                r_cy <= sp_cell;
                r_wy <= sp_w;
                r_g  <= '0;
                for (int k = 0; k < 4; k++) r_sacc[k] <= '0;
            end
            mfvn_pkg::ST_HACC: begin
                for (int k = 0; k < 4; k++) r_sacc[k] <= r_sacc[k] + h_contrib[k];
                r_g    <= r_g + 4'd1;
                r_lsel <= 2'd0;
            end
            mfvn_pkg::ST_LTAKE: begin
                case (r_lsel)
                    2'd0:    r_i1 <= l_res;
                    2'd1:    r_i2 <= l_res;
                    default: r_nz <= mfvn_pkg::t_q'(l_res);
                endcase
                r_lsel <= r_lsel + 2'd1;
            end
            mfvn_pkg::ST_OINIT: begin
                r_amp  <= m_amp0;
                r_ret  <= mfvn_pkg::Q_ONE;
                r_oct  <= oct_iters;
                r_msel <= 2'd0;
                r_pp   <= 2'd0;
            end
            mfvn_pkg::ST_MPP: begin
                case (r_pp)
                    2'd0:    r_acc <= '0;
                    2'd1:    r_acc <= r_prod << 30;
                    default: r_acc <= r_acc + r_prod;
                endcase
                r_pp <= r_pp + 2'd1;
            end
            mfvn_pkg::ST_MFIN: begin
                case (r_msel)
                    2'd0:    r_t1   <= m_res;
                    2'd1:    r_term <= m_res;
                    2'd2:    r_ret  <= m_res;
                    default: r_amp  <= m_res;
                endcase
                if (m_clamp) r_sat <= 1'b1;
                if (r_msel == 2'd3) r_oct <= r_oct - OW'(1);
                r_msel <= r_msel + 2'd1;
            end
            mfvn_pkg::ST_OUT: begin
                r_out_val <= ret_q16;
                r_out_sat <= r_sat;
            end
            default: ;
        endcase
    end

    // result strobe, high in the cycle after the ST_OUT state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == mfvn_pkg::ST_OUT);
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    always_comb begin
        busy            = (r_state != mfvn_pkg::ST_IDLE);
        o_strobe        = r_strobe;
        o_fractal_value = r_out_val;
        o_saturated     = r_out_sat;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_strobe_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == mfvn_pkg::ST_OUT))
        else $error("strobe without a finished request");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("strobe while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but sequencer did not start");

    a_octave_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfvn_pkg::ST_MPP) |-> (r_oct != '0))
        else $error("octave product with no octave left");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: multifractal value noise testbench
// drives points through the command port, predicts each fractal value and
// saturation flag in fixed point, and checks every strobed result in order
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  DEPTH     = 256;
    localparam int  OCT_MAX   = 16;
    localparam int  WD_LIMIT  = 20000;
    localparam longint Q1     = 64'sd1 << 30;
    localparam longint HI_Q   = (64'sd1 << 45) - (64'sd1 << 14);
    localparam longint LO_MAG = 64'sd1 << 45;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_x_coord;
    logic [31:0] i_y_coord;
    logic        o_strobe;
    logic [31:0] o_fractal_value;
    logic        o_saturated;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    multifractal_value_noise u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .o_strobe       (o_strobe),
        .o_fractal_value(o_fractal_value),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // model copy of the configuration registers
    logic [4:0]  m_octaves;
    logic [23:0] m_freq;
    logic [19:0] m_amp;
    logic [17:0] m_ratio;
    logic [19:0] m_offs;

    // expected fractal value with its saturation flag in bit 32
    logic [32:0] exp_fractal_q[$];
    int          fail_count;
    int          idle_cycles;
    longint      blend_lut[DEPTH + 1];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    // taylor cosine, q2.30, written out independently of the block
    function automatic longint taylor_cos(longint unsigned a);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (a * a) >> 30;
        term = 64'd1 << 30;
        sum  = Q1;
        for (int k = 1; k <= 9; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2) sum -= longint'(term);
            else       sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > Q1) sum = Q1;
        return sum;
    endfunction

    function automatic longint lattice_val(logic [31:0] x, logic [31:0] y);
        logic [31:0] n;
        logic [31:0] v;
        n = (x + y * 32'd57) & 32'hFFFF;
        n = ((n << 13) ^ n) & 32'hFFFF;
        if (n[15]) n = n | 32'hFFFF_0000;
        v = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
        return Q1 - longint'({1'b0, v[30:0]});
    endfunction

    function automatic longint smoothed(logic [31:0] x, logic [31:0] y);
        longint c, s, z;
        c = lattice_val(x - 1, y - 1) + lattice_val(x + 1, y - 1)
          + lattice_val(x - 1, y + 1) + lattice_val(x + 1, y + 1);
        s = lattice_val(x - 1, y) + lattice_val(x + 1, y)
          + lattice_val(x, y - 1) + lattice_val(x, y + 1);
        z = lattice_val(x, y);
        return floor_sh(c + 2 * s + 4 * z, 4);
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + floor_sh((b - a) * w, 30);
    endfunction

    // q.30 product truncated toward zero, clamped to the q16.16 range
    function automatic longint qmul(longint a, longint b, inout bit sat);
        bit              neg;
        longint unsigned ua, ub, r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        r   = (((ua >> 30) * (ub >> 30)) << 30) + (ua >> 30) * (ub & 30'h3FFF_FFFF)
            + (ua & 30'h3FFF_FFFF) * (ub >> 30)
            + (((ua & 30'h3FFF_FFFF) * (ub & 30'h3FFF_FFFF)) >> 30);
        if (neg) begin
            if (r > LO_MAG) begin
                sat = 1'b1;
                return -LO_MAG;
            end
            return -longint'(r);
        end
        if (r > HI_Q) begin
            sat = 1'b1;
            return HI_Q;
        end
        return longint'(r);
    endfunction

    // scaled coordinate: cell truncated toward zero, table index from |fraction|
    function automatic void split_point(input logic [31:0] raw,
                                        output logic [31:0] lat_cell, output int idx);
        longint p, ip, fr;
        p        = longint'($signed(raw)) * longint'({1'b0, m_freq});
        ip       = p / (64'sd1 << 32);
        fr       = p - ip * (64'sd1 << 32);
        if (fr < 0) fr = -fr;
        lat_cell = ip[31:0];
        idx      = int'((fr * DEPTH) >>> 32);
    endfunction

    function automatic logic [32:0] predict_fractal(logic [31:0] xc, logic [31:0] yc);
        logic [31:0] cx, cy;
        int          ix, iy;
        longint      wx, wy, i1, i2, nz, amp, ratio, offs, prod, term, t1;
        int          count, steps;
        bit          sat;
        sat = 1'b0;
        split_point(xc, cx, ix);
        split_point(yc, cy, iy);
        wx = blend_lut[ix];
        wy = blend_lut[iy];
        i1 = blend(smoothed(cx, cy), smoothed(cx + 1, cy), wx);
        i2 = blend(smoothed(cx, cy + 1), smoothed(cx + 1, cy + 1), wx);
        nz = blend(i1, i2, wy);
        amp   = longint'($signed(m_amp)) * 16384;
        ratio = longint'($signed(m_ratio)) * 16384;
        offs  = longint'($signed(m_offs)) * 16384;
        prod  = Q1;
        count = (m_octaves > OCT_MAX) ? OCT_MAX : int'(m_octaves);
        steps = (count > 1) ? count - 1 : 0;
        for (int i = 0; i < steps; i++) begin
            t1   = qmul(offs, nz, sat);
            term = qmul(t1, amp, sat);
            prod = qmul(prod, term, sat);
            amp  = qmul(amp, ratio, sat);
        end
        prod = prod / 16384;
        return {sat, prod[31:0]};
    endfunction

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    // send one request and queue its expected result
    task automatic send_point(input logic [31:0] xc, input logic [31:0] yc);
        @(posedge i_clk);
        start     <= 1'b1;
        i_x_coord <= xc;
        i_y_coord <= yc;
        exp_fractal_q.push_back(predict_fractal(xc, yc));
        do @(posedge i_clk); while (busy);
        start <= 1'b0;
    endtask

    // random gap between bursts of requests
    task automatic sender_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
        repeat (gap) @(posedge i_clk);
    endtask

    // wait until every result is back, then a margin for the sequencer
    task automatic drain();
        while (exp_fractal_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // write enable is dropped by the caller after the last write
    task automatic write_reg(input mfvn_pkg::t_cfg_idx idx, input logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            mfvn_pkg::CFG_OCTAVE_COUNT:    m_octaves = val[4:0];
            mfvn_pkg::CFG_BASE_FREQUENCY:  m_freq    = val;
            mfvn_pkg::CFG_START_AMPLITUDE: m_amp     = val[19:0];
            mfvn_pkg::CFG_AMPLITUDE_RATIO: m_ratio   = val[17:0];
            mfvn_pkg::CFG_OCTAVE_OFFSET:   m_offs    = val[19:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [4:0] oct, input logic [23:0] freq,
                              input logic [19:0] amp, input logic [17:0] ratio,
                              input logic [19:0] offs);
        drain();
        write_reg(mfvn_pkg::CFG_OCTAVE_COUNT, {19'd0, oct});
        write_reg(mfvn_pkg::CFG_BASE_FREQUENCY, freq);
        write_reg(mfvn_pkg::CFG_START_AMPLITUDE, {4'd0, amp});
        write_reg(mfvn_pkg::CFG_AMPLITUDE_RATIO, {6'd0, ratio});
        write_reg(mfvn_pkg::CFG_OCTAVE_OFFSET, {4'd0, offs});
        i_cfg_we <= 1'b0;
    endtask

    // random point, mostly near the origin so lattice cells repeat
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            default: return 32'($signed(20'($urandom())));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_point(32'h0001_8000, 32'h0002_4000);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'hFFFF_8000, 32'hFFFE_C000);
    endtask

    task automatic test_directed_extremes();
        // no octaves, one octave, then octave count above the maximum
        set_config(5'd0, 24'd65536, 20'h10000, 18'h08000, 20'h10000);
        send_point(32'h1234_5678, 32'h8765_4321);
        set_config(5'd1, 24'd65536, 20'h10000, 18'h08000, 20'h10000);
        send_point(32'h0003_0000, 32'h0004_0000);
        set_config(5'd31, 24'hFFFFFF, 20'h7FFFF, 18'h1FFFF, 20'h7FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        // clamping with negative extremes
        set_config(5'd16, 24'h010000, 20'h80000, 18'h20000, 20'h80000);
        send_point(32'h0000_4000, 32'hFFFF_C000);
        send_point(32'hFFFF_0001, 32'h0000_FFFF);
        // far lattice points with a zero and a tiny frequency
        set_config(5'd3, 24'd0, 20'h10000, 18'h10000, 20'h20000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_config(5'd5, 24'd1, 20'hF0000, 18'h3C000, 20'h30000);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_points(input int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                // mostly small octave counts keep the run short
                set_config(($urandom_range(0, 7) == 0) ? 5'($urandom())
                                                       : 5'($urandom_range(0, 5)),
                           ($urandom_range(0, 1) == 1) ? 24'($urandom())
                                                       : 24'($urandom_range(0, 24'h40000)),
                           20'($urandom()), 18'($urandom()), 20'($urandom()));
            end
            if (burst == 0) begin
                sender_gap();
                burst = $urandom_range(1, 12);
            end
            burst--;
            send_point(rand_coord(), rand_coord());
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: the receiver cannot stall, every strobe is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [32:0] want;
        if (i_rst_n && o_strobe) begin
            if (exp_fractal_q.size() == 0) begin
                report_mismatch("unexpected result", o_fractal_value, 32'd0);
            end else begin
                want = exp_fractal_q.pop_front();
                if (o_fractal_value !== want[31:0])
                    report_mismatch("fractal_value", o_fractal_value, want[31:0]);
                if (o_saturated !== want[32])
                    report_mismatch("saturated", {31'd0, o_saturated}, {31'd0, want[32]});
            end
        end
    end

    // watchdog on cycles with no accepted request and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WD_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        start       = 1'b0;
        i_x_coord   = '0;
        i_y_coord   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = mfvn_pkg::CFG_OCTAVE_COUNT;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        fail_count  = 0;
        m_octaves   = 5'd4;
        m_freq      = 24'd65536;
        m_amp       = 20'h10000;
        m_ratio     = 18'h08000;
        m_offs      = 20'h10000;
        // blend weight table, the upper half mirrors the cosine
        for (int i = 0; i <= DEPTH; i++) begin
            if (2 * i <= DEPTH)
                blend_lut[i] = (Q1 - taylor_cos(64'd3373259426 * i / DEPTH)) >>> 1;
            else
                blend_lut[i] = (Q1 + taylor_cos(64'd3373259426 * (DEPTH - i) / DEPTH)) >>> 1;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_extremes();
        test_random_points(1850);
        drain();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- multifractal_value_noise.f -----
src/mfvn_pkg.sv
src/multifractal_value_noise.sv
sim/tb_top.sv
